[src/fcrgb_pkg.sv]
// ----------------------------------------------------------------------------
// fcrgb_pkg
// Shared types and constants for the fire color to RGB PWM pipeline.
// ----------------------------------------------------------------------------
package fcrgb_pkg;

  // Gamma table geometry
  localparam int GAMMA_ENTRIES = 4096;
  localparam int GAMMA_AW      = $clog2(GAMMA_ENTRIES);
  localparam int DUTY_W        = 12;

  // Item kinds carried on tuser
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_FRAME = 1'b1;

  // Number of color channels (red, green, blue)
  localparam int NUM_CH = 3;
  localparam int CH_RED   = 0;
  localparam int CH_GREEN = 1;
  localparam int CH_BLUE  = 2;

  // Register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_HUE_START = 3'd0,
    REG_HUE_END   = 3'd1,
    REG_PEAK      = 3'd2,
    REG_SPREAD    = 3'd3,
    REG_RED_GAIN  = 3'd4,
    REG_GRN_GAIN  = 3'd5,
    REG_BLU_GAIN  = 3'd6
  } reg_idx_t;

  // Reset values
  localparam logic [14:0] RST_HUE_START = 15'd1000;
  localparam logic [14:0] RST_HUE_END   = 15'd3000;
  localparam logic [13:0] RST_PEAK      = 14'd5400;
  localparam logic [12:0] RST_SPREAD    = 13'd250;
  localparam logic [12:0] RST_RED_GAIN  = 13'd4096;
  localparam logic [12:0] RST_GRN_GAIN  = 13'd2949;
  localparam logic [12:0] RST_BLU_GAIN  = 13'd3072;

  // Configuration register file contents
  typedef struct packed {
    logic [14:0] hue_start;
    logic [14:0] hue_end;
    logic [13:0] peak;
    logic [12:0] spread;
    logic [NUM_CH-1:0][12:0] gain;
  } cfg_t;

  // Load item fields carried down the pipe
  typedef struct packed {
    logic              kind;
    logic [GAMMA_AW-1:0] tidx;
    logic [DUTY_W-1:0]   tval;
  } load_t;

  // Front section result: intensity offset and hexagon RGB
  typedef struct packed {
    load_t                   ld;
    logic [12:0]             ioff;
    logic [NUM_CH-1:0][11:0] chan;
  } front_t;

  // Scale section result: gamma addresses (load address in lane 0)
  typedef struct packed {
    logic                        kind;
    logic [NUM_CH-1:0][GAMMA_AW-1:0] idx;
    logic [DUTY_W-1:0]           wval;
  } gidx_t;

endpackage

[src/fcrgb_gamma_ram.sv]
// ----------------------------------------------------------------------------
// fcrgb_gamma_ram
// One-write one-read gamma table memory with registered read data.
// ----------------------------------------------------------------------------
module fcrgb_gamma_ram import fcrgb_pkg::*; (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [GAMMA_AW-1:0] wr_addr,
  input  logic [DUTY_W-1:0]   wr_data,
  input  logic                rd_en,
  input  logic [GAMMA_AW-1:0] rd_addr,
  output logic [DUTY_W-1:0]   rd_data
);

  logic [DUTY_W-1:0] mem_r [GAMMA_ENTRIES];
  logic [DUTY_W-1:0] rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // Registered read port, held while rd_en is low
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[src/fcrgb_front.sv]
// ----------------------------------------------------------------------------
// fcrgb_front
// Stages 1-3: wave saturation, deviation and hue products, hexagon to RGB.
// ----------------------------------------------------------------------------
module fcrgb_front import fcrgb_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  load_t              in_ld,
  input  logic signed [13:0] in_hue_wave,
  input  logic signed [13:0] in_int_wave,
  output logic               out_valid,
  input  logic               out_ready,
  output front_t             out_data
);

  // Clamp a wave sample to -4096..4096
  function automatic logic signed [13:0] sat_wave(input logic signed [13:0] x);
    logic signed [13:0] y;
    y = x;
    if (x < -14'sd4096) y = -14'sd4096;
    if (x > 14'sd4096)  y = 14'sd4096;
    return y;
  endfunction

  logic v1_r, v2_r, v3_r;
  logic rdy1, rdy2, rdy3;

  // Stage registers
  load_t              ld1_r, ld2_r;
  logic [12:0]        hue1_r, hue2_r;
  logic signed [13:0] iw1_r;
  logic signed [27:0] devp2_r;
  logic signed [29:0] huep2_r;
  front_t             s3_r;

  // Stage 1 combinational
  logic signed [13:0] hw_sat;
  logic [13:0]        hue_sum;

  // Stage 2 combinational
  logic signed [15:0] diff;
  logic signed [27:0] devp_nxt;
  logic signed [29:0] huep_nxt;

  // Stage 3 combinational
  logic signed [27:0] devadj;
  logic signed [15:0] dev;
  logic signed [16:0] inten;
  logic signed [16:0] inten_cl;
  logic signed [17:0] step;
  logic signed [18:0] pos;
  logic [14:0]        pos_cl;
  logic [2:0]         sector;
  logic [11:0]        ci, cd;
  front_t             s3_nxt;

  // Ready chain: a stage moves when it is empty or its successor moves
  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  // Stage 1: saturate waves, shift hue into 0..4096
  always_comb begin
    hw_sat  = sat_wave(in_hue_wave);
    hue_sum = 14'(hw_sat) + 14'd4096;
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      ld1_r  <= in_ld;
      hue1_r <= hue_sum[13:1];
      iw1_r  <= sat_wave(in_int_wave);
    end
  end

  // Stage 2: deviation product and hue range product
  always_comb begin
    diff     = $signed({1'b0, cfg.hue_end}) - $signed({1'b0, cfg.hue_start});
    devp_nxt = iw1_r * $signed({1'b0, cfg.spread});
    huep_nxt = $signed({1'b0, hue1_r}) * diff;
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      ld2_r   <= ld1_r;
      hue2_r  <= hue1_r;
      devp2_r <= devp_nxt;
      huep2_r <= huep_nxt;
    end
  end

  // Stage 3: intensity offset and hexagon color
  always_comb begin
    // deviation divided by 4096, truncated toward zero
    devadj = devp2_r + (devp2_r[27] ? 28'sd4095 : 28'sd0);
    dev    = devadj[27:12];
    inten  = $signed({4'b0000, hue2_r}) + {dev[15], dev};
    if (inten < -17'sd4096) begin
      inten_cl = -17'sd4096;
    end else if (inten > 17'sd4095) begin
      inten_cl = 17'sd4095;
    end else begin
      inten_cl = inten;
    end

    // hue position, floor division of the product
    step   = huep2_r[29:12];
    pos    = {step[17], step} + $signed({4'b0000, cfg.hue_start});
    pos_cl = pos[18] ? 15'd0 : pos[14:0];
    sector = pos_cl[14:12];
    ci     = pos_cl[11:0];
    cd     = ~ci;

    s3_nxt      = '0;
    s3_nxt.ld   = ld2_r;
    s3_nxt.ioff = 13'(inten_cl + 17'sd4096);
    case (sector)
      3'd0: begin
        s3_nxt.chan[CH_RED] = 12'hFFF; s3_nxt.chan[CH_GREEN] = ci;
      end
      3'd1: begin
        s3_nxt.chan[CH_RED] = cd; s3_nxt.chan[CH_GREEN] = 12'hFFF;
      end
      3'd2: begin
        s3_nxt.chan[CH_GREEN] = 12'hFFF; s3_nxt.chan[CH_BLUE] = ci;
      end
      3'd3: begin
        s3_nxt.chan[CH_GREEN] = cd; s3_nxt.chan[CH_BLUE] = 12'hFFF;
      end
      3'd4: begin
        s3_nxt.chan[CH_RED] = ci; s3_nxt.chan[CH_BLUE] = 12'hFFF;
      end
      3'd5: begin
        s3_nxt.chan[CH_RED] = 12'hFFF; s3_nxt.chan[CH_BLUE] = cd;
      end
      default: begin
        s3_nxt.chan = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_r <= s3_nxt;
    end
  end

  assign out_valid = v3_r;
  assign out_data  = s3_r;

endmodule

[src/fcrgb_scale.sv]
// ----------------------------------------------------------------------------
// fcrgb_scale
// Stages 4-7: gain and intensity products, white blend, gamma address.
// ----------------------------------------------------------------------------
module fcrgb_scale import fcrgb_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  cfg_t   cfg,
  input  logic   in_valid,
  output logic   in_ready,
  input  front_t in_data,
  output logic   out_valid,
  input  logic   out_ready,
  output gidx_t  out_data
);

  logic v4_r, v5_r, v6_r, v7_r;
  logic rdy4, rdy5, rdy6, rdy7;

  load_t ld4_r, ld5_r, ld6_r;
  logic [26:0]             iprod4_r;
  logic [NUM_CH-1:0][24:0] gprod4_r;
  logic [NUM_CH-1:0][12:0] sc5_r;
  logic [11:0]             mul5_r, add5_r, add6_r;
  logic [NUM_CH-1:0][24:0] p6_r;
  gidx_t                   s7_r;

  logic [26:0]             iprod_nxt;
  logic [NUM_CH-1:0][24:0] gprod_nxt;
  logic [13:0]             sint_raw;
  logic [12:0]             sint;
  logic [NUM_CH-1:0][24:0] p_nxt;
  logic [NUM_CH-1:0][13:0] sum;
  gidx_t                   s7_nxt;

  // Ready chain
  assign rdy7     = !v7_r || out_ready;
  assign rdy6     = !v6_r || rdy7;
  assign rdy5     = !v5_r || rdy6;
  assign rdy4     = !v4_r || rdy5;
  assign in_ready = rdy4;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else begin
      if (rdy4) v4_r <= in_valid;
      if (rdy5) v5_r <= v4_r;
      if (rdy6) v6_r <= v5_r;
      if (rdy7) v7_r <= v6_r;
    end
  end

  // Stage 4: intensity times peak, channels times gain
  always_comb begin
    iprod_nxt = 27'(in_data.ioff) * 27'(cfg.peak);
    for (int c = 0; c < NUM_CH; c++) begin
      gprod_nxt[c] = 25'(in_data.chan[c]) * 25'(cfg.gain[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      ld4_r    <= in_data.ld;
      iprod4_r <= iprod_nxt;
      gprod4_r <= gprod_nxt;
    end
  end

  // Stage 5: saturate intensity, choose scale factor and white offset
  always_comb begin
    sint_raw = iprod4_r[26:13];
    sint     = sint_raw[13] ? 13'h1FFF : sint_raw[12:0];
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      ld5_r <= ld4_r;
      for (int c = 0; c < NUM_CH; c++) begin
        sc5_r[c] <= gprod4_r[c][24:12];
      end
      // above 4095 the factor is 4095 minus the excess, excess is added back
      mul5_r <= sint[12] ? ~sint[11:0] : sint[11:0];
      add5_r <= sint[12] ? sint[11:0] : 12'd0;
    end
  end

  // Stage 6: channel times intensity factor
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      p_nxt[c] = 25'(sc5_r[c]) * 25'(mul5_r);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy6) begin
      ld6_r  <= ld5_r;
      p6_r   <= p_nxt;
      add6_r <= add5_r;
    end
  end

  // Stage 7: add white offset, saturate to table range
  always_comb begin
    s7_nxt      = '0;
    s7_nxt.kind = ld6_r.kind;
    s7_nxt.wval = ld6_r.tval;
    for (int c = 0; c < NUM_CH; c++) begin
      sum[c] = 14'(p6_r[c][24:12]) + 14'(add6_r);
      s7_nxt.idx[c] = (sum[c] > 14'(GAMMA_ENTRIES - 1)) ?
                      GAMMA_AW'(GAMMA_ENTRIES - 1) : sum[c][GAMMA_AW-1:0];
    end
    if (ld6_r.kind == KIND_LOAD) begin
      s7_nxt.idx[CH_RED] = ld6_r.tidx;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy7) begin
      s7_r <= s7_nxt;
    end
  end

  assign out_valid = v7_r;
  assign out_data  = s7_r;

endmodule

[src/fire_color_to_rgb_pwm.sv]
// ----------------------------------------------------------------------------
// fire_color_to_rgb_pwm
// Fire flicker hue and intensity waves to gamma corrected RGB PWM duties.
// ----------------------------------------------------------------------------
// One item is accepted per clock while in_tready is high; out_tready held low
// can stall the pipe. The pipe has eight register stages (three front stages,
// four scale stages, one gamma read stage), and the first one is loaded by the
// edge that accepts an item. A frame item passes through all of them in order
// and then raises out_tvalid; a load item gives no result. Every multiply
// result is registered before it is used. The gamma table is three copies of
// a 4096 x 12 RAM, one read port per color, all written by the same load
// item; it is not cleared, so every entry a frame can reach must be loaded
// before frames are sent. Loads and frames keep their order, so a load
// followed by a frame is seen by that frame. The user must write registers
// over the cfg_ port only while the pipe is empty; the block itself does not
// enforce this.
module fire_color_to_rgb_pwm import fcrgb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // table_index[11:0], table_value[23:12],
                                  // hue_wave[37:24], intensity_wave[51:38]
  input  logic        in_tuser,   // kind
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // red_duty[11:0], green_duty[23:12],
                                  // blue_duty[35:24]
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  cfg_t     cfg_r;
  reg_idx_t reg_sel;
  logic     cfg_wr;

  load_t  in_ld;
  logic   f_valid, f_ready;
  front_t f_data;
  logic   s_valid, s_ready;
  gidx_t  s_data;

  logic out_valid_r;
  logic ram_we, ram_re, xfer7;
  logic [NUM_CH-1:0][DUTY_W-1:0] duty;

  // Configuration registers
  assign cfg_pready = 1'b1;
  assign reg_sel    = reg_idx_t'(cfg_paddr[4:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hue_start      <= RST_HUE_START;
      cfg_r.hue_end        <= RST_HUE_END;
      cfg_r.peak           <= RST_PEAK;
      cfg_r.spread         <= RST_SPREAD;
      cfg_r.gain[CH_RED]   <= RST_RED_GAIN;
      cfg_r.gain[CH_GREEN] <= RST_GRN_GAIN;
      cfg_r.gain[CH_BLUE]  <= RST_BLU_GAIN;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_HUE_START: cfg_r.hue_start      <= cfg_pwdata[14:0];
        REG_HUE_END:   cfg_r.hue_end        <= cfg_pwdata[14:0];
        REG_PEAK:      cfg_r.peak           <= cfg_pwdata[13:0];
        REG_SPREAD:    cfg_r.spread         <= cfg_pwdata[12:0];
        REG_RED_GAIN:  cfg_r.gain[CH_RED]   <= cfg_pwdata[12:0];
        REG_GRN_GAIN:  cfg_r.gain[CH_GREEN] <= cfg_pwdata[12:0];
        REG_BLU_GAIN:  cfg_r.gain[CH_BLUE]  <= cfg_pwdata[12:0];
        default: ;
      endcase
    end
  end

  // Register read back
  always_comb begin
    case (reg_sel)
      REG_HUE_START: cfg_prdata = 32'(cfg_r.hue_start);
      REG_HUE_END:   cfg_prdata = 32'(cfg_r.hue_end);
      REG_PEAK:      cfg_prdata = 32'(cfg_r.peak);
      REG_SPREAD:    cfg_prdata = 32'(cfg_r.spread);
      REG_RED_GAIN:  cfg_prdata = 32'(cfg_r.gain[CH_RED]);
      REG_GRN_GAIN:  cfg_prdata = 32'(cfg_r.gain[CH_GREEN]);
      REG_BLU_GAIN:  cfg_prdata = 32'(cfg_r.gain[CH_BLUE]);
      default:       cfg_prdata = 32'd0;
    endcase
  end

  // Input unpacking
  assign in_ld.kind = in_tuser;
  assign in_ld.tidx = in_tdata[11:0];
  assign in_ld.tval = in_tdata[23:12];

  fcrgb_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_ld       (in_ld),
    .in_hue_wave ($signed(in_tdata[37:24])),
    .in_int_wave ($signed(in_tdata[51:38])),
    .out_valid   (f_valid),
    .out_ready   (f_ready),
    .out_data    (f_data)
  );

  fcrgb_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   (f_data),
    .out_valid (s_valid),
    .out_ready (s_ready),
    .out_data  (s_data)
  );

  // Stage 8: gamma access and output register
  assign s_ready = !out_valid_r || out_tready;
  assign xfer7   = s_valid && s_ready;
  assign ram_we  = xfer7 && (s_data.kind == KIND_LOAD);
  assign ram_re  = xfer7 && (s_data.kind == KIND_FRAME);

  for (genvar c = 0; c < NUM_CH; c++) begin : g_gamma
    fcrgb_gamma_ram u_ram (
      .clk     (clk),
      .wr_en   (ram_we),
      .wr_addr (s_data.idx[CH_RED]),
      .wr_data (s_data.wval),
      .rd_en   (ram_re),
      .rd_addr (s_data.idx[c]),
      .rd_data (duty[c])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s_ready) begin
      out_valid_r <= ram_re;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, duty[CH_BLUE], duty[CH_GREEN], duty[CH_RED]};

  // Checks
  a_rw_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("gamma write and read in the same cycle");

  a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |=> !out_valid_r)
    else $error("load item produced a result");

  a_result_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(ram_re))
    else $error("result appeared without a gamma read");

  a_hold_read: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !ram_re)
    else $error("gamma read overwrote a waiting result");

endmodule
